// ===== design/ttr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttr_pkg: shared definitions for the tile to raster reorder block
// Default geometry limits, field widths and configuration register indexes.
// ----------------------------------------------------------------------------
package ttr_pkg;

    localparam int TILE_SIZE_DEF  = 8;
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 2;
    localparam int BPP_W        = 3;
    localparam int PLANE_W      = 2;
    localparam int BYTE_W       = 8;
    localparam int OFFSET_W     = 26;

    localparam logic [BPP_W-1:0] BPP_RESET = 3'd3;
    localparam logic [BPP_W-1:0] BPP_MAX   = 3'd4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH     = 2'd0,
        REG_IMAGE_HEIGHT    = 2'd1,
        REG_BYTES_PER_PIXEL = 2'd2
    } t_cfg_reg;

endpackage
`default_nettype wire

// ===== design/tile_to_raster_reorder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tile_to_raster_reorder: tiled planar stream to interleaved raster offsets
// Walks the tile, row and plane counters of a clipped tiled planar image and
// gives each byte its offset in the interleaved raster image.
// ----------------------------------------------------------------------------
// Beats pass through the s1, s2 and output registers, one beat per cycle
// while the output is not stalled; the position counters advance in one step
// and the offset goes through a multiply stage and a plane scaling stage.
// A stalled output holds the pipeline, and empty stages still take new beats.
// Reset sets width and height to 1, bytes per pixel to 3 and clears all
// counters; any configuration write clears the counters as well.
// ----------------------------------------------------------------------------
module tile_to_raster_reorder #(
    parameter int TILE_SIZE  = ttr_pkg::TILE_SIZE_DEF,
    parameter int MAX_WIDTH  = ttr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ttr_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [ttr_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [ttr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [ttr_pkg::BYTE_W-1:0]       i_in_byte,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic [ttr_pkg::OFFSET_W-1:0]          o_raster_offset,
    output logic [ttr_pkg::BYTE_W-1:0]            o_out_byte,
    output logic                                  o_frame_done
);
    import ttr_pkg::*;

    localparam int XW  = $clog2(MAX_WIDTH + 1);
    localparam int YW  = $clog2(MAX_HEIGHT + 1);
    localparam int TW  = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;
    localparam int PXW = XW + YW + 1;
    localparam int OFW = PXW + BPP_W;

    // Configuration, stored already clamped.
    logic [XW-1:0]      r_width;
    logic [YW-1:0]      r_height;
    logic [BPP_W-1:0]   r_bpp;

    // Position counters.
    logic [XW-1:0]      r_x0, n_x0;
    logic [YW-1:0]      r_y0, n_y0;
    logic [TW-1:0]      r_cit, n_cit;
    logic [TW-1:0]      r_rit, n_rit;
    logic [PLANE_W-1:0] r_plane, n_plane;

    // Pipeline stages.
    logic               r_s1_valid, r_s2_valid, r_out_valid;
    logic [YW-1:0]      r_s1_row;
    logic [XW-1:0]      r_s1_col;
    logic [PLANE_W-1:0] r_s1_plane, r_s2_plane;
    logic [BYTE_W-1:0]  r_s1_byte, r_s2_byte, r_out_byte;
    logic               r_s1_done, r_s2_done, r_out_done;
    logic [PXW-1:0]     r_s2_pix;
    logic [OFFSET_W-1:0] r_out_offset;

    logic en1, en2, en3, accept;
    logic [XW:0]    w_col_p1, w_x0_next;
    logic [YW:0]    w_row_p1, w_y0_next;
    logic           col_end, row_end, tcol_end, trow_end, plane_end, done;
    logic [XW-1:0]  w_col;
    logic [YW-1:0]  w_row;
    logic [OFW-1:0] w_offset;

    assign en3    = !r_out_valid || i_ready;
    assign en2    = !r_s2_valid || en3;
    assign en1    = !r_s1_valid || en2;
    assign o_ready = en1;
    assign accept = i_valid && en1;

    assign w_col     = r_x0 + XW'(r_cit);
    assign w_row     = r_y0 + YW'(r_rit);
    assign w_col_p1  = {1'b0, w_col} + (XW+1)'(1);
    assign w_row_p1  = {1'b0, w_row} + (YW+1)'(1);
    assign w_x0_next = {1'b0, r_x0} + (XW+1)'(TILE_SIZE);
    assign w_y0_next = {1'b0, r_y0} + (YW+1)'(TILE_SIZE);

    assign col_end   = (w_col_p1 == {1'b0, r_width}) || (r_cit == TW'(TILE_SIZE - 1));
    assign row_end   = (w_row_p1 == {1'b0, r_height}) || (r_rit == TW'(TILE_SIZE - 1));
    assign tcol_end  = w_x0_next >= {1'b0, r_width};
    assign trow_end  = w_y0_next >= {1'b0, r_height};
    assign plane_end = ({1'b0, r_plane} + BPP_W'(1)) >= r_bpp;
    assign done      = col_end && row_end && tcol_end && trow_end && plane_end;

    always_comb begin
        n_cit   = r_cit;
        n_rit   = r_rit;
        n_x0    = r_x0;
        n_y0    = r_y0;
        n_plane = r_plane;
        if (!col_end) begin
            n_cit = r_cit + TW'(1);
        end else begin
            n_cit = '0;
            if (!row_end) begin
                n_rit = r_rit + TW'(1);
            end else begin
                n_rit = '0;
                if (!tcol_end) begin
                    n_x0 = w_x0_next[XW-1:0];
                end else begin
                    n_x0 = '0;
                    if (!trow_end) begin
                        n_y0 = w_y0_next[YW-1:0];
                    end else begin
                        n_y0 = '0;
                        if (!plane_end) begin
                            n_plane = r_plane + PLANE_W'(1);
                        end else begin
                            n_plane = '0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= XW'(1);
            r_height <= YW'(1);
            r_bpp    <= BPP_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH: begin
                    if (i_cfg_data == '0) begin
                        r_width <= XW'(1);
                    end else if (int'(i_cfg_data) > MAX_WIDTH) begin
                        r_width <= XW'(MAX_WIDTH);
                    end else begin
                        r_width <= XW'(i_cfg_data);
                    end
                end
                REG_IMAGE_HEIGHT: begin
                    if (i_cfg_data == '0) begin
                        r_height <= YW'(1);
                    end else if (int'(i_cfg_data) > MAX_HEIGHT) begin
                        r_height <= YW'(MAX_HEIGHT);
                    end else begin
                        r_height <= YW'(i_cfg_data);
                    end
                end
                REG_BYTES_PER_PIXEL: begin
                    case (i_cfg_data[BPP_W-1:0]) inside
                        3'd0:         r_bpp <= BPP_W'(1);
                        [3'd5:3'd7]:  r_bpp <= BPP_MAX;
                        default:      r_bpp <= i_cfg_data[BPP_W-1:0];
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en) begin
            r_x0    <= '0;
            r_y0    <= '0;
            r_cit   <= '0;
            r_rit   <= '0;
            r_plane <= '0;
        end else if (accept) begin
            r_x0    <= n_x0;
            r_y0    <= n_y0;
            r_cit   <= n_cit;
            r_rit   <= n_rit;
            r_plane <= n_plane;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1) begin
                r_s1_valid <= accept;
            end
            if (en2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (en3) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    assign w_offset = OFW'(r_s2_pix) * OFW'(r_bpp) + OFW'(r_s2_plane);

    always_ff @(posedge i_clk) begin
        if (en1 && accept) begin
            r_s1_row   <= w_row;
            r_s1_col   <= w_col;
            r_s1_plane <= r_plane;
            r_s1_byte  <= i_in_byte;
            r_s1_done  <= done;
        end
        if (en2 && r_s1_valid) begin
            r_s2_pix   <= PXW'(r_s1_row) * PXW'(r_width) + PXW'(r_s1_col);
            r_s2_plane <= r_s1_plane;
            r_s2_byte  <= r_s1_byte;
            r_s2_done  <= r_s1_done;
        end
        if (en3 && r_s2_valid) begin
            r_out_offset <= w_offset[OFFSET_W-1:0];
            r_out_byte   <= r_s2_byte;
            r_out_done   <= r_s2_done;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_raster_offset = r_out_offset;
    assign o_out_byte      = r_out_byte;
    assign o_frame_done    = r_out_done;

endmodule
`default_nettype wire
